FILE: hdl/expression_tokenizer_defines.svh
// Assertion macros used by the checker file.
`ifndef EXPRESSION_TOKENIZER_DEFINES_SVH
`define EXPRESSION_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define ET_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define ET_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/et_pkg.sv
package et_pkg;

  localparam int MAX_TEXT_LEN = 4096;
  localparam int OFS_W = 12;
  localparam int VAL_W = 31;
  localparam logic [OFS_W-1:0] OFFSET_CAP =
    OFS_W'(((MAX_TEXT_LEN - 1) < 4095) ? (MAX_TEXT_LEN - 1) : 4095);
  localparam logic [VAL_W-1:0] VALUE_MAX = 31'h7FFF_FFFF;

  // Token record queue between the scanner and the output stage.
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_NUM  = 3'd1,
    M_PEQ  = 3'd2,
    M_PNOT = 3'd3,
    M_PLT  = 3'd4,
    M_PGT  = 3'd5,
    M_ERR  = 3'd6
  } scan_mode_t;

  typedef enum logic [3:0] {
    T_NUM    = 4'd0,
    T_EOF    = 4'd1,
    T_EQ     = 4'd2,
    T_NE     = 4'd3,
    T_LE     = 4'd4,
    T_GE     = 4'd5,
    T_PLUS   = 4'd6,
    T_MINUS  = 4'd7,
    T_STAR   = 4'd8,
    T_SLASH  = 4'd9,
    T_LPAREN = 4'd10,
    T_RPAREN = 4'd11,
    T_LT     = 4'd12,
    T_GT     = 4'd13,
    T_ERR    = 4'd14
  } tok_type_t;

  typedef struct packed {
    tok_type_t              ttype;
    logic [VAL_W-1:0]       value;
    logic [OFS_W-1:0]       offset;
  } token_t;

  // All tokens caused by one input beat; tok1 is used only when two is set.
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } rec_beat_t;

endpackage

FILE: hdl/et_front.sv
module et_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char_in,
  input  logic              in_end_of_text,
  input  logic              space,
  output et_pkg::rec_beat_t push
);
  import et_pkg::*;

  scan_mode_t        mode_r, mode_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic [OFS_W-1:0]  start_r, start_nxt;
  logic [OFS_W-1:0]  off_r, off_nxt;

  logic              accept;
  logic              is_end;
  logic              is_digit;
  logic              is_eq;
  logic [3:0]        digit;
  logic [34:0]       prod;
  logic [VAL_W-1:0]  acc_sat;
  logic [OFS_W-1:0]  off_inc;

  scan_mode_t        idle_mode;
  logic              idle_emit;
  logic              idle_start;
  tok_type_t         idle_type;

  logic              ea, eb;
  token_t            ta, tb;

  assign in_ready = space;
  assign accept   = in_valid && space;
  assign is_end   = in_end_of_text || (in_char_in == CH_NUL);
  assign is_digit = (in_char_in >= CH_ZERO) && (in_char_in <= CH_NINE);
  assign is_eq    = (in_char_in == CH_EQ);
  assign digit    = 4'(in_char_in - CH_ZERO);
  assign off_inc  = (off_r < OFFSET_CAP) ? off_r + 1'b1 : off_r;

  // acc * 10 + digit, clamped to the largest 31-bit value.
  assign prod    = 35'({acc_r, 3'b000}) + 35'({acc_r, 1'b0}) + 35'(digit);
  assign acc_sat = (|prod[34:31]) ? VALUE_MAX : prod[VAL_W-1:0];

  // What a byte does when nothing is pending.
  always_comb begin
    idle_mode  = M_IDLE;
    idle_emit  = 1'b0;
    idle_start = 1'b0;
    idle_type  = T_ERR;
    case (in_char_in)
      CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE: begin
        idle_mode = M_IDLE;
      end
      CH_EQ: begin
        idle_mode  = M_PEQ;
        idle_start = 1'b1;
      end
      CH_BANG: begin
        idle_mode  = M_PNOT;
        idle_start = 1'b1;
      end
      CH_LT: begin
        idle_mode  = M_PLT;
        idle_start = 1'b1;
      end
      CH_GT: begin
        idle_mode  = M_PGT;
        idle_start = 1'b1;
      end
      CH_PLUS: begin
        idle_emit = 1'b1;
        idle_type = T_PLUS;
      end
      CH_MINUS: begin
        idle_emit = 1'b1;
        idle_type = T_MINUS;
      end
      CH_STAR: begin
        idle_emit = 1'b1;
        idle_type = T_STAR;
      end
      CH_SLASH: begin
        idle_emit = 1'b1;
        idle_type = T_SLASH;
      end
      CH_LPAR: begin
        idle_emit = 1'b1;
        idle_type = T_LPAREN;
      end
      CH_RPAR: begin
        idle_emit = 1'b1;
        idle_type = T_RPAREN;
      end
      default: begin
        if (is_digit) begin
          idle_mode  = M_NUM;
          idle_start = 1'b1;
        end else begin
          idle_mode = M_ERR;
          idle_emit = 1'b1;
          idle_type = T_ERR;
        end
      end
    endcase
  end

  // Next scanner mode.
  always_comb begin
    mode_nxt = mode_r;
    if (is_end) begin
      mode_nxt = M_IDLE;
    end else begin
      case (mode_r)
        M_ERR:         mode_nxt = M_ERR;
        M_NUM:         mode_nxt = is_digit ? M_NUM : idle_mode;
        M_PEQ, M_PNOT: mode_nxt = is_eq ? M_IDLE : M_ERR;
        M_PLT, M_PGT:  mode_nxt = is_eq ? M_IDLE : idle_mode;
        default:       mode_nxt = idle_mode;
      endcase
    end
  end

  // Tokens and datapath state. Slot a is the flushed pending token, slot b
  // is the token of the current byte (or EOF).
  always_comb begin
    ea        = 1'b0;
    eb        = 1'b0;
    ta        = '0;
    tb        = '0;
    acc_nxt   = acc_r;
    start_nxt = start_r;
    off_nxt   = off_inc;
    ta.offset = start_r;
    tb.ttype  = idle_type;
    tb.offset = off_r;
    if (is_end) begin
      acc_nxt   = '0;
      start_nxt = '0;
      off_nxt   = '0;
      tb.ttype  = T_EOF;
      if (mode_r != M_ERR) begin
        eb = 1'b1;
        case (mode_r)
          M_NUM: begin
            ea       = 1'b1;
            ta.ttype = T_NUM;
            ta.value = acc_r;
          end
          M_PLT: begin
            ea       = 1'b1;
            ta.ttype = T_LT;
          end
          M_PGT: begin
            ea       = 1'b1;
            ta.ttype = T_GT;
          end
          M_PEQ, M_PNOT: begin
            ea       = 1'b1;
            ta.ttype = T_ERR;
          end
          default: begin
            ea = 1'b0;
          end
        endcase
      end
    end else begin
      case (mode_r)
        M_ERR: begin
          ea = 1'b0;
        end
        M_NUM: begin
          if (is_digit) begin
            acc_nxt = acc_sat;
          end else begin
            ea       = 1'b1;
            ta.ttype = T_NUM;
            ta.value = acc_r;
            acc_nxt  = '0;
            eb       = idle_emit;
            if (idle_start) begin
              start_nxt = off_r;
            end
          end
        end
        M_PEQ, M_PNOT: begin
          ea = 1'b1;
          if (!is_eq) begin
            ta.ttype = T_ERR;
          end else if (mode_r == M_PEQ) begin
            ta.ttype = T_EQ;
          end else begin
            ta.ttype = T_NE;
          end
        end
        M_PLT, M_PGT: begin
          ea = 1'b1;
          if (is_eq) begin
            ta.ttype = (mode_r == M_PLT) ? T_LE : T_GE;
          end else begin
            ta.ttype = (mode_r == M_PLT) ? T_LT : T_GT;
            eb       = idle_emit;
            if (idle_start) begin
              start_nxt = off_r;
            end
            if (idle_mode == M_NUM) begin
              acc_nxt = VAL_W'(digit);
            end
          end
        end
        default: begin
          eb = idle_emit;
          if (idle_start) begin
            start_nxt = off_r;
          end
          if (idle_mode == M_NUM) begin
            acc_nxt = VAL_W'(digit);
          end
        end
      endcase
    end
  end

  assign push.valid    = accept && (ea || eb);
  assign push.rec.tok0 = ea ? ta : tb;
  assign push.rec.tok1 = tb;
  assign push.rec.two  = ea && eb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      acc_r   <= '0;
      start_r <= '0;
      off_r   <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      start_r <= start_nxt;
      off_r   <= off_nxt;
    end
  end

endmodule

FILE: hdl/et_queue.sv
module et_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  et_pkg::rec_beat_t push,
  output logic              space,
  output et_pkg::rec_beat_t head,
  input  logic              pop
);
  import et_pkg::*;

  rec_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;

  assign space      = (cnt_r != (QAW+1)'(QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push.valid ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QAW+1)'(push.valid) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/et_back.sv
module et_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  et_pkg::rec_beat_t        head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [3:0]               out_token_type,
  output logic [et_pkg::VAL_W-1:0] out_number_value,
  output logic [et_pkg::OFS_W-1:0] out_start_offset,
  output logic                     out_last_of_run
);
  import et_pkg::*;

  logic    valid_r, valid_nxt;
  logic    sel_r, sel_nxt;
  token_t  tok_r;
  logic    last_r;
  logic    load;
  logic    take;
  token_t  cur;

  // The output register reloads when it is empty or its beat is taken.
  assign load = !valid_r || out_ready;
  assign take = load && head.valid;
  assign pop  = take && (sel_r || !head.rec.two);
  assign cur  = sel_r ? head.rec.tok1 : head.rec.tok0;

  always_comb begin
    valid_nxt = load ? head.valid : valid_r;
    sel_nxt   = sel_r;
    if (take) begin
      sel_nxt = !pop;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_r  <= cur;
      last_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_token_type   = tok_r.ttype;
  assign out_number_value = tok_r.value;
  assign out_start_offset = tok_r.offset;
  assign out_last_of_run  = last_r;

endmodule

FILE: hdl/expression_tokenizer.sv
// Expression tokenizer: one text byte per beat in, one token per beat out.
// A token passes through the token queue and the output register before it shows on out_valid.
// Throughput: one byte per cycle while the token queue has space; a byte that yields two tokens uses
// two output beats, absorbed by the four-entry token queue behind the scanner.
// Reset (rst_n low, synchronous) returns the scanner to offset 0 in idle mode
// and empties the queue and the output register.
module expression_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_type,
  output logic [30:0] out_number_value,
  output logic [11:0] out_start_offset,
  output logic        out_last_of_run
);
  import et_pkg::*;

  rec_beat_t push;
  rec_beat_t head;
  logic      space;
  logic      pop;

  et_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_in     (in_char_in),
    .in_end_of_text (in_end_of_text),
    .space          (space),
    .push           (push)
  );

  et_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .space (space),
    .head  (head),
    .pop   (pop)
  );

  et_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_type   (out_token_type),
    .out_number_value (out_number_value),
    .out_start_offset (out_start_offset),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

FILE: hdl/et_checker.sv
`include "expression_tokenizer_defines.svh"

module et_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_token_type,
  input logic [30:0] out_number_value,
  input logic [11:0] out_start_offset,
  input logic        out_last_of_run
);
  import et_pkg::*;

  logic        out_stall;
  logic        out_fire;
  logic        num_tok;
  logic        eof_tok;
  logic [47:0] out_beat;

  assign out_stall = out_valid && !out_ready;
  assign out_fire  = out_valid && out_ready;
  assign num_tok   = (out_token_type == T_NUM);
  assign eof_tok   = (out_token_type == T_EOF);
  assign out_beat  = {out_token_type, out_number_value, out_start_offset, out_last_of_run};

  `ET_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_beat), "stalled beat changed")
  `ET_ASSERT_IMP(a_value_num, out_valid && !num_tok, out_number_value == '0, "stray number value")
  `ET_ASSERT_IMP(a_eof_last, out_valid && eof_tok, out_last_of_run, "EOF is not last")
  `ET_ASSERT_NXT(a_second_follows, out_fire && !out_last_of_run, out_valid, "second token missing")

endmodule

bind expression_tokenizer et_checker u_et_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_token_type   (out_token_type),
  .out_number_value (out_number_value),
  .out_start_offset (out_start_offset),
  .out_last_of_run  (out_last_of_run)
);

FILE: tb/expression_tokenizer_tb.sv
`timescale 1ns / 100ps

module expression_tokenizer_tb;
  import et_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int END_FLAG = 0;
  localparam int END_ZERO = 1;

  typedef struct {
    tok_type_t        ttype;
    logic [VAL_W-1:0] value;
    logic [OFS_W-1:0] offset;
    logic             last;
  } token_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_in = 8'h00;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_token_type;
  logic [30:0] out_number_value;
  logic [11:0] out_start_offset;
  logic        out_last_of_run;

  expression_tokenizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_in       (in_char_in),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_type   (out_token_type),
    .out_number_value (out_number_value),
    .out_start_offset (out_start_offset),
    .out_last_of_run  (out_last_of_run)
  );

  always #4 clk = ~clk;

  // Scanner state as the tokenizer should hold it.
  scan_mode_t       scan_st = M_IDLE;
  logic [VAL_W-1:0] num_acc = '0;
  logic [OFS_W-1:0] tok_start = '0;
  logic [OFS_W-1:0] next_ofs = '0;

  token_exp_t  step_toks[$];
  token_exp_t  expected_tokens[$];
  token_exp_t  head_tok;
  logic [7:0]  text_bytes[$];
  int          mismatches = 0;
  int          sent_bytes = 0;

  bit tx_bursty = 1'b0;
  int burst_left = 0;
  bit rx_stalls = 1'b0;
  bit rx_on = 1'b1;
  int rx_run = 0;
  int hold_req = 0;
  int hold_left = 0;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void emit_tok(input tok_type_t t, input logic [VAL_W-1:0] v,
                                   input logic [OFS_W-1:0] o);
    token_exp_t e;
    e.ttype = t;
    e.value = v;
    e.offset = o;
    e.last = 1'b0;
    step_toks.push_back(e);
  endfunction

  function automatic void clear_scanner();
    scan_st = M_IDLE;
    num_acc = '0;
    tok_start = '0;
    next_ofs = '0;
  endfunction

  // Tokenize a byte as if nothing were pending.
  function automatic void lex_fresh(input logic [7:0] c, input logic [OFS_W-1:0] o);
    case (c)
      CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: ;
      CH_EQ: begin
        scan_st = M_PEQ;
        tok_start = o;
      end
      CH_BANG: begin
        scan_st = M_PNOT;
        tok_start = o;
      end
      CH_LT: begin
        scan_st = M_PLT;
        tok_start = o;
      end
      CH_GT: begin
        scan_st = M_PGT;
        tok_start = o;
      end
      CH_PLUS:  emit_tok(T_PLUS, '0, o);
      CH_MINUS: emit_tok(T_MINUS, '0, o);
      CH_STAR:  emit_tok(T_STAR, '0, o);
      CH_SLASH: emit_tok(T_SLASH, '0, o);
      CH_LPAR:  emit_tok(T_LPAREN, '0, o);
      CH_RPAR:  emit_tok(T_RPAREN, '0, o);
      default: begin
        if (is_digit(c)) begin
          scan_st = M_NUM;
          num_acc = VAL_W'(c - CH_ZERO);
          tok_start = o;
        end else begin
          emit_tok(T_ERR, '0, o);
          scan_st = M_ERR;
        end
      end
    endcase
  endfunction

  function automatic void predict_tokens(input logic [7:0] c, input logic eot);
    logic [OFS_W-1:0] o;
    logic [63:0]      grown;
    tok_type_t        pair;
    token_exp_t       e;
    step_toks.delete();
    if (eot || c == CH_NUL) begin
      // In error mode the end only clears the scanner, without an EOF.
      if (scan_st != M_ERR) begin
        case (scan_st)
          M_NUM:        emit_tok(T_NUM, num_acc, tok_start);
          M_PLT:        emit_tok(T_LT, '0, tok_start);
          M_PGT:        emit_tok(T_GT, '0, tok_start);
          M_PEQ, M_PNOT: emit_tok(T_ERR, '0, tok_start);
          default: ;
        endcase
        emit_tok(T_EOF, '0, next_ofs);
      end
      clear_scanner();
    end else begin
      o = next_ofs;
      if (next_ofs < OFFSET_CAP) next_ofs = next_ofs + 1'b1;
      case (scan_st)
        M_ERR: ;
        M_NUM: begin
          if (is_digit(c)) begin
            grown = 64'(num_acc) * 64'd10 + 64'(c - CH_ZERO);
            num_acc = (grown > 64'(VALUE_MAX)) ? VALUE_MAX : grown[VAL_W-1:0];
          end else begin
            emit_tok(T_NUM, num_acc, tok_start);
            scan_st = M_IDLE;
            num_acc = '0;
            lex_fresh(c, o);
          end
        end
        M_PEQ, M_PNOT, M_PLT, M_PGT: begin
          if (c == CH_EQ) begin
            case (scan_st)
              M_PEQ:   pair = T_EQ;
              M_PNOT:  pair = T_NE;
              M_PLT:   pair = T_LE;
              default: pair = T_GE;
            endcase
            emit_tok(pair, '0, tok_start);
            scan_st = M_IDLE;
          end else if (scan_st == M_PEQ || scan_st == M_PNOT) begin
            // The byte after a lone = or ! is swallowed by the error.
            emit_tok(T_ERR, '0, tok_start);
            scan_st = M_ERR;
          end else begin
            if (scan_st == M_PLT) emit_tok(T_LT, '0, tok_start);
            else emit_tok(T_GT, '0, tok_start);
            scan_st = M_IDLE;
            lex_fresh(c, o);
          end
        end
        default: begin
          scan_st = M_IDLE;
          lex_fresh(c, o);
        end
      endcase
    end
    foreach (step_toks[i]) begin
      e = step_toks[i];
      e.last = (i == step_toks.size() - 1);
      expected_tokens.push_back(e);
    end
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    $display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Sends one byte beat; with tx_bursty set, the sender runs in bursts with random gaps between most of them.
  task automatic send_byte(input logic [7:0] c, input logic eot);
    int gap;
    gap = 0;
    if (tx_bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= c;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    predict_tokens(c, eot);
    sent_bytes++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  task automatic send_text(input int end_kind);
    foreach (text_bytes[i]) send_byte(text_bytes[i], 1'b0);
    if (end_kind == END_ZERO) send_byte(CH_NUL, 1'b0);
    else send_byte(8'($urandom), 1'b1);
    text_bytes.delete();
  endtask

  function automatic void push_string(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endfunction

  function automatic void push_space();
    case ($urandom_range(0, 5))
      0: text_bytes.push_back(CH_TAB);
      1: text_bytes.push_back(CH_LF);
      2: text_bytes.push_back(CH_VT);
      3: text_bytes.push_back(CH_FF);
      4: text_bytes.push_back(CH_CR);
      default: text_bytes.push_back(CH_SPACE);
    endcase
  endfunction

  function automatic void push_operator(input int unsigned k);
    case (k)
      0: text_bytes.push_back(CH_PLUS);
      1: text_bytes.push_back(CH_MINUS);
      2: text_bytes.push_back(CH_STAR);
      3: text_bytes.push_back(CH_SLASH);
      4: text_bytes.push_back(CH_LPAR);
      5: text_bytes.push_back(CH_RPAR);
      6: text_bytes.push_back(CH_LT);
      7: text_bytes.push_back(CH_GT);
      8: begin
        text_bytes.push_back(CH_EQ);
        text_bytes.push_back(CH_EQ);
      end
      9: begin
        text_bytes.push_back(CH_BANG);
        text_bytes.push_back(CH_EQ);
      end
      10: begin
        text_bytes.push_back(CH_LT);
        text_bytes.push_back(CH_EQ);
      end
      default: begin
        text_bytes.push_back(CH_GT);
        text_bytes.push_back(CH_EQ);
      end
    endcase
  endfunction

  // Mostly short numbers, some long enough to saturate, some right at the limit.
  function automatic void push_number();
    longint unsigned v;
    int              pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) v = $urandom_range(0, 999);
    else if (pick < 85) v = $urandom;
    else if (pick < 92) v = {$urandom, $urandom};
    else v = 64'd2147483640 + $urandom_range(0, 15);
    if ($urandom_range(0, 9) == 0) text_bytes.push_back(CH_ZERO);
    push_string($sformatf("%0d", v));
  endfunction

  // Well-formed expression pieces with a little noise mixed in.
  function automatic void build_random_text();
    int pieces;
    int r;
    pieces = $urandom_range(0, 14);
    repeat (pieces) begin
      r = $urandom_range(0, 99);
      if (r < 38) push_number();
      else if (r < 72) push_operator($urandom_range(0, 11));
      else if (r < 89) repeat ($urandom_range(1, 3)) push_space();
      else if (r < 94) text_bytes.push_back($urandom_range(0, 1) ? CH_EQ : CH_BANG);
      else text_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic test_directed();
    tx_bursty = 1'b0;
    rx_stalls = 1'b0;
    // Every operator but +, whitespace, a pending < resolved by >, a number flushed by the end.
    push_string("(12 <=>===!=-*/)<>9");
    send_text(END_FLAG);
    // A lone = ends in error; the zero byte then clears quietly.
    push_string("=x");
    send_text(END_ZERO);
    // A lone ! at the end gives an error and then EOF.
    text_bytes.push_back(CH_BANG);
    send_text(END_FLAG);
    // A pending < is flushed by a zero byte.
    text_bytes.push_back(CH_LT);
    send_text(END_ZERO);
    // An illegal byte; the digit after it is ignored.
    text_bytes.push_back(8'hFF);
    text_bytes.push_back(CH_NINE);
    send_text(END_FLAG);
    wait_drain();
  endtask

  task automatic test_random_texts(input int byte_goal, input bit idling);
    int goal;
    tx_bursty = idling;
    rx_stalls = idling;
    goal = sent_bytes + byte_goal;
    while (sent_bytes < goal) begin
      build_random_text();
      send_text(($urandom_range(0, 3) == 0) ? END_ZERO : END_FLAG);
    end
    wait_drain();
  endtask

  // The receiver holds off while bytes keep coming, so the token queue fills up.
  task automatic test_back_pressure();
    tx_bursty = 1'b0;
    rx_stalls = 1'b1;
    hold_req = HOLD_CYCLES;
    repeat (30) begin
      text_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      push_operator($urandom_range(0, 11));
    end
    send_text(END_FLAG);
    wait_drain();
  endtask

  // Unless held, the receiver is always ready, or with rx_stalls set alternates ready and stall runs of random length.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!rx_stalls) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        rx_on = !rx_on;
        rx_run = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 5);
      end
      rx_run--;
      out_ready <= rx_on;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected token, type", out_token_type, 0);
      end else begin
        head_tok = expected_tokens.pop_front();
        if (out_token_type !== head_tok.ttype)
          report_mismatch("token_type", out_token_type, head_tok.ttype);
        if (out_number_value !== head_tok.value)
          report_mismatch("number_value", out_number_value, head_tok.value);
        if (out_start_offset !== head_tok.offset)
          report_mismatch("start_offset", out_start_offset, head_tok.offset);
        if (out_last_of_run !== head_tok.last)
          report_mismatch("last_of_run", out_last_of_run, head_tok.last);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_texts(800, 1'b1);
    test_back_pressure();
    test_random_texts(400, 1'b0);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
